// ----- design/qed_pkg.sv -----
`timescale 1ns / 1ps
package qed_pkg;

  localparam int unsigned BufferDepth  = 32;
  localparam int unsigned CntW         = $clog2(BufferDepth + 1);
  localparam int unsigned AddrW        = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int unsigned CmdFifoDepth = 2;
  localparam int unsigned CmdPtrW      = 1;
  localparam int unsigned CmdCntW      = 2;

  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChEscape = 8'h5C;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       end_mark;
    logic       overflow;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_EMIT,
    CMD_HOLD,
    CMD_DRAIN,
    CMD_END
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
    logic       quote_open;
  } cmd_t;

endpackage

// ----- design/qed_ram.sv -----
`timescale 1ns / 1ps
module qed_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                                           clk_i,
  input  logic                                           we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   waddr_i,
  input  logic [Width-1:0]                               wdata_i,
  input  logic                                           re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   raddr_i,
  output logic [Width-1:0]                               rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/qed_front.sv -----
`timescale 1ns / 1ps
module qed_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  qed_pkg::in_item_t in_item_i,
  input  logic             cmd_full_i,
  output logic             full_o,
  output logic             cmd_push_o,
  output qed_pkg::cmd_t    cmd_o
);
  import qed_pkg::*;

  logic in_quote_q, in_quote_d;
  logic esc_q, esc_d;
  logic accept;
  logic need_cmd;

  assign full_o = cmd_full_i;
  assign accept = push_i && !cmd_full_i;

  always_comb begin
    in_quote_d = in_quote_q;
    esc_d      = esc_q;
    need_cmd   = 1'b0;
    cmd_o.op         = CMD_EMIT;
    cmd_o.data       = in_item_i.char_in;
    cmd_o.quote_open = in_quote_q;
    if (in_item_i.kind) begin
      need_cmd   = 1'b1;
      cmd_o.op   = CMD_END;
      in_quote_d = 1'b0;
      esc_d      = 1'b0;
    end else if (esc_q) begin
      need_cmd = 1'b1;
      esc_d    = 1'b0;
      cmd_o.op = in_quote_q ? CMD_HOLD : CMD_EMIT;
    end else if (in_item_i.char_in == ChEscape) begin
      esc_d = 1'b1;
    end else if (in_item_i.char_in == ChDquote) begin
      in_quote_d = !in_quote_q;
      need_cmd   = in_quote_q;
      cmd_o.op   = CMD_DRAIN;
    end else begin
      need_cmd = 1'b1;
      cmd_o.op = in_quote_q ? CMD_HOLD : CMD_EMIT;
    end
  end

  assign cmd_push_o = accept && need_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quote_q <= 1'b0;
      esc_q      <= 1'b0;
    end else if (accept) begin
      in_quote_q <= in_quote_d;
      esc_q      <= esc_d;
    end
  end

endmodule

// ----- design/qed_cmd_fifo.sv -----
`timescale 1ns / 1ps
module qed_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qed_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output qed_pkg::cmd_t rdata_o
);
  import qed_pkg::*;

  cmd_t                 slot_q [CmdFifoDepth];
  logic [CmdPtrW-1:0]   wptr_q, rptr_q;
  logic [CmdCntW-1:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CmdCntW'(CmdFifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + CmdPtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + CmdPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CmdCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CmdCntW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CmdCntW'(CmdFifoDepth))
    else $error("command queue count out of range");

endmodule

// ----- design/qed_back.sv -----
`timescale 1ns / 1ps
module qed_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  qed_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output qed_pkg::out_item_t out_item_o
);
  import qed_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QUOTE = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic            ovf_q, ovf_d;
  logic            end_q, end_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  logic            can_load;
  logic            load;
  logic            we, re;
  logic [7:0]      rdata;
  logic            at_last;

  qed_ram #(
    .Width(8),
    .Depth(BufferDepth)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_q[AddrW-1:0]),
    .wdata_i(cmd_i.data),
    .re_i   (re),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  assign can_load = !out_valid_q || pop_i;
  assign at_last  = (CntW'(idx_q) == cnt_q - CntW'(1));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    ovf_d     = ovf_q;
    end_d     = end_q;
    out_d     = out_q;
    load      = 1'b0;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            CMD_HOLD: begin
              cmd_pop_o = 1'b1;
              if (cnt_q < CntW'(BufferDepth)) begin
                we    = 1'b1;
                cnt_d = cnt_q + CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_EMIT: begin
              if (can_load) begin
                cmd_pop_o = 1'b1;
                load      = 1'b1;
                out_d     = '{char_out: cmd_i.data, end_mark: 1'b0, overflow: 1'b0,
                              last: 1'b1};
              end
            end
            CMD_DRAIN: begin
              cmd_pop_o = 1'b1;
              end_d     = 1'b0;
              idx_d     = '0;
              if (cnt_q != '0) begin
                state_d = S_RD;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
              end_d     = 1'b1;
              idx_d     = '0;
              state_d   = cmd_i.quote_open ? S_QUOTE : S_MARK;
            end
          endcase
        end
      end
      S_QUOTE: begin
        if (can_load) begin
          load    = 1'b1;
          out_d   = '{char_out: ChDquote, end_mark: 1'b0, overflow: 1'b0, last: 1'b0};
          state_d = (cnt_q != '0) ? S_RD : S_MARK;
        end
      end
      S_RD: begin
        re      = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (can_load) begin
          load  = 1'b1;
          out_d = '{char_out: rdata, end_mark: 1'b0, overflow: 1'b0,
                    last: at_last && !end_q};
          if (at_last) begin
            cnt_d   = '0;
            state_d = end_q ? S_MARK : S_IDLE;
          end else begin
            idx_d   = idx_q + AddrW'(1);
            state_d = S_RD;
          end
        end
      end
      S_MARK: begin
        if (can_load) begin
          load    = 1'b1;
          out_d   = '{char_out: 8'h00, end_mark: 1'b1, overflow: ovf_q, last: 1'b1};
          cnt_d   = '0;
          ovf_d   = 1'b0;
          end_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      ovf_q       <= ovf_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(BufferDepth))
    else $error("held count beyond buffer depth");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_OUT) |-> (CntW'(idx_q) < cnt_q))
    else $error("drain index past held count");

  a_mark_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.end_mark) |-> (out_q.char_out == 8'h00 && out_q.last))
    else $error("end marker malformed");

  a_no_cmd_mid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd_pop_o)
    else $error("command taken while busy");

endmodule

// ----- design/quote_escape_decoder_core.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake                     payload
// input     in   push / full (accept: push & !full)   in_item_i  (kind, char_in)
// result    out  empty / pop (accept: pop & !empty)   out_item_o (char_out, end_mark,
//                                                                 overflow, last)
// plain byte: loaded straight to the output; held byte: written into the quote buffer
// closing quote: the command is taken, then each held byte gets one buffer read and
//   one output load
// end: the command is taken, then the literal quote when a span is open, a read and a
//   load per held byte, and last the marker
// the front classifies at the input and feeds a two-entry command queue, so input is
//   taken while the back end drains; full rises only when that queue is full
// reset clears all control state at once; the quote buffer needs no clearing pass
module quote_escape_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  qed_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output qed_pkg::out_item_t out_item_o
);
  import qed_pkg::*;

  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t cmd_in, cmd_out;

  qed_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_item_i (in_item_i),
    .cmd_full_i(cmd_full),
    .full_o    (full),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_in)
  );

  qed_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .rdata_o(cmd_out)
  );

  qed_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import qed_pkg::*;

  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;
  localparam int unsigned MaxGap = 12;

  typedef struct {
    in_item_t item;
    bit       sync;
  } tx_entry_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  in_item_t   in_item_i = '0;
  out_item_t  out_item_o;

  quote_escape_decoder_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o)
  );

  // decoder state mirror
  bit         in_span;
  bit         escape_armed;
  logic [7:0] span_bytes[$];
  bit         span_dropped;
  out_item_t  decoded[$];
  out_item_t  expected_out[$];

  tx_entry_t  tx_pending[$];
  bit         sync_next;
  bit         tx_burst;
  bit         rx_burst;
  int unsigned gap_left;
  int unsigned stall_left;

  int unsigned items_in;
  int unsigned strings_in;
  int unsigned results_seen;
  int unsigned overflow_marks;
  int unsigned open_span_ends;
  int unsigned mismatches;
  int unsigned stray_results;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void put_char(logic [7:0] ch, logic mark, logic ovf);
    out_item_t r;
    r.char_out = ch;
    r.end_mark = mark;
    r.overflow = ovf;
    r.last     = 1'b0;
    decoded.push_back(r);
  endfunction

  function automatic void keep_in_span(logic [7:0] b);
    if (span_bytes.size() < BufferDepth) span_bytes.push_back(b);
    else span_dropped = 1'b1;
  endfunction

  function automatic void release_span();
    foreach (span_bytes[i]) put_char(span_bytes[i], 1'b0, 1'b0);
    span_bytes.delete();
  endfunction

  function automatic void decode_item(in_item_t it);
    decoded.delete();
    if (it.kind == KindEnd) begin
      if (in_span) begin
        open_span_ends++;
        put_char(ChDquote, 1'b0, 1'b0);
        release_span();
      end
      put_char(8'h00, 1'b1, span_dropped);
      in_span      = 1'b0;
      escape_armed = 1'b0;
      span_dropped = 1'b0;
      span_bytes.delete();
    end else if (escape_armed) begin
      escape_armed = 1'b0;
      if (in_span) keep_in_span(it.char_in);
      else put_char(it.char_in, 1'b0, 1'b0);
    end else if (it.char_in == ChEscape) begin
      escape_armed = 1'b1;
    end else if (it.char_in == ChDquote) begin
      if (in_span) release_span();
      in_span = !in_span;
    end else if (in_span) begin
      keep_in_span(it.char_in);
    end else begin
      put_char(it.char_in, 1'b0, 1'b0);
    end
    if (decoded.size() > 0) decoded[decoded.size() - 1].last = 1'b1;
    foreach (decoded[i]) expected_out.push_back(decoded[i]);
  endfunction

  function automatic int unsigned draw_wait(inout bit burst);
    if ($urandom_range(0, 15) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // sender
  always @(posedge clk_i) begin : drive
    tx_entry_t nxt;
    if (rst_ni) begin
      if (push && !full) begin
        decode_item(in_item_i);
        items_in++;
        if (in_item_i.kind == KindEnd) strings_in++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (tx_pending.size() > 0 &&
                     (!tx_pending[0].sync || expected_out.size() == 0)) begin
          nxt = tx_pending.pop_front();
          in_item_i <= nxt.item;
          push      <= 1'b1;
          gap_left  = draw_wait(tx_burst);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  function automatic void report(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s: expected char %02h end %0b ovf %0b last %0b, ",
                "got char %02h end %0b ovf %0b last %0b"},
               what, want.char_out, want.end_mark, want.overflow, want.last,
               got.char_out, got.end_mark, got.overflow, got.last);
  endfunction

  // receiver
  always @(posedge clk_i) begin : collect
    out_item_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        results_seen++;
        if (out_item_o.end_mark === 1'b1 && out_item_o.overflow === 1'b1) overflow_marks++;
        if (expected_out.size() == 0) begin
          stray_results++;
          report("unexpected result", '0, out_item_o);
        end else begin
          want = expected_out.pop_front();
          if (out_item_o.char_out !== want.char_out || out_item_o.end_mark !== want.end_mark ||
              out_item_o.overflow !== want.overflow || out_item_o.last !== want.last)
            report("result mismatch", want, out_item_o);
        end
        stall_left = draw_wait(rx_burst);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      pop <= (stall_left == 0);
    end
  end

  function automatic void queue_item(logic kind, logic [7:0] ch);
    tx_entry_t e;
    e.item.kind    = kind;
    e.item.char_in = ch;
    e.sync         = sync_next;
    sync_next      = 1'b0;
    tx_pending.push_back(e);
  endfunction

  function automatic void queue_bytes(string s);
    for (int i = 0; i < s.len(); i++) queue_item(KindByte, s[i]);
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 3))
      0: return ChDquote;
      1: return ChEscape;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one well-formed string with random content
  function automatic void queue_string(bit force_long);
    int unsigned tokens;
    int unsigned len;
    bit          leave_open;
    tokens = force_long ? 1 : $urandom_range(1, 6);
    for (int t = 0; t < tokens; t++) begin
      case (force_long ? 6 : $urandom_range(0, 9))
        0, 1, 2, 3: queue_item(KindByte, 8'($urandom_range(0, 255)));
        4: begin
          queue_item(KindByte, ChEscape);
          queue_item(KindByte, pick_special());
        end
        5, 6, 7: begin
          len = (force_long || $urandom_range(0, 5) == 0) ? $urandom_range(28, 40)
                                                        : $urandom_range(0, 6);
          leave_open = force_long || (t == tokens - 1 && $urandom_range(0, 3) == 0);
          queue_item(KindByte, ChDquote);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) == 0) begin
              queue_item(KindByte, ChEscape);
              queue_item(KindByte, pick_special());
            end else begin
              queue_item(KindByte, 8'($urandom_range(0, 255)));
            end
          end
          if (!leave_open) queue_item(KindByte, ChDquote);
        end
        8: begin
          queue_item(KindByte, ChEscape);
          queue_item(KindByte, ($urandom_range(0, 1) == 0) ? ChDquote : ChEscape);
        end
        default: queue_item(KindByte, 8'h00);
      endcase
    end
    if ($urandom_range(0, 7) == 0) queue_item(KindByte, ChEscape);
    queue_item(KindEnd, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void queue_noise();
    int unsigned len;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) queue_item(KindByte, pick_special());
    queue_item(KindEnd, 8'($urandom_range(0, 255)));
  endfunction

  initial begin
    // extremes and plain pass-through
    queue_item(KindByte, 8'h00);
    queue_item(KindByte, 8'hFF);
    queue_item(KindByte, "A");
    queue_item(KindEnd, 8'hFF);
    // escaped backslash and escaped quote
    queue_bytes("\\\\\\\"");
    queue_item(KindEnd, 8'h00);
    // quoted span with a zero byte inside
    queue_item(KindByte, ChDquote);
    queue_item(KindByte, "a");
    queue_item(KindByte, 8'h00);
    queue_item(KindByte, ChDquote);
    queue_item(KindEnd, 8'h55);
    // empty span
    queue_item(KindByte, ChDquote);
    queue_item(KindByte, ChDquote);
    queue_item(KindEnd, 8'hAA);
    // unclosed span holding an escaped quote
    queue_item(KindByte, ChDquote);
    queue_item(KindByte, ChEscape);
    queue_item(KindByte, ChDquote);
    queue_item(KindByte, "z");
    queue_item(KindEnd, 8'h22);
    // trailing lone backslash
    queue_item(KindByte, "q");
    queue_item(KindByte, ChEscape);
    queue_item(KindEnd, 8'h5C);
    // empty string
    queue_item(KindEnd, 8'h00);

    // random part, first string holds a long open span that may overflow the span buffer
    sync_next = 1'b1;
    queue_string(1'b1);
    while (tx_pending.size() < 200) begin
      if (tx_pending.size() > 120 && tx_pending.size() < 140) sync_next = 1'b1;
      if ($urandom_range(0, 4) == 0) queue_noise();
      else queue_string($urandom_range(0, 19) == 0);
    end

    while (tx_pending.size() > 0 || push) @(posedge clk_i);
    while (expected_out.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("sent %0d items in %0d strings, checked %0d results",
             items_in, strings_in, results_seen);
    $display("%0d markers flagged overflow, %0d strings ended inside a span",
             overflow_marks, open_span_ends);
    if (mismatches == 0 && stray_results == 0 && expected_out.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
